>>> rtl/htfd_pkg.sv
// Shared types, constants and the CRC-8 step for the sensor frame decoder.
// No dependencies; every other file but htfd_if refers to it by scoped names.
package htfd_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam int TEMP_SCALE  = 17500;
	localparam int TEMP_OFFSET = -4500;
	localparam int HUMID_SCALE = 10000;
	localparam int FULL_SCALE  = 65535;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		POS_T_MSB = 3'd0,
		POS_T_LSB = 3'd1,
		POS_T_CRC = 3'd2,
		POS_H_MSB = 3'd3,
		POS_H_LSB = 3'd4,
		POS_H_CRC = 3'd5
	} pos_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TEMP_CRC  = 2'd1,
		ST_HUMID_CRC = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0] temp_raw;
		logic [15:0] humid_raw;
		status_t     status;
	} meas_t;

	function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/htfd_if.sv
// Channel interfaces of the frame decoder: received bytes in, measurements out.
// Depends on nothing.
interface htfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source(output valid, rx_byte, frame_start, input ready);
	modport sink(input valid, rx_byte, frame_start, output ready);
endinterface

interface htfd_result_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;
	logic [1:0]         status;

	modport source(output valid, temperature_centi, humidity_centi, status, input ready);
	modport sink(input valid, temperature_centi, humidity_centi, status, output ready);
endinterface

>>> rtl/htfd_front.sv
// Front end: tracks frame position, runs the CRC, assembles the raw words and
// pushes one record per frame. Depends on htfd_pkg and htfd_byte_if.
module htfd_front (
	input  logic              clk,
	input  logic              arst_n,
	htfd_byte_if.sink         rx,
	output logic              push_valid,
	output htfd_pkg::meas_t   push_data,
	input  logic              push_ready
);

	htfd_pkg::pos_t pos_q, pos_d, pos_eff;
	logic [7:0]     crc_q, crc_d;
	logic [15:0]    temp_q, temp_d;
	logic [15:0]    humid_q, humid_d;
	logic           tfail_q, tfail_d;
	logic           accept;

	assign rx.ready = push_ready;
	assign accept   = rx.valid && push_ready;

	always_comb begin
		pos_eff = rx.frame_start ? htfd_pkg::POS_T_MSB : pos_q;
		pos_d   = pos_q;
		crc_d   = crc_q;
		temp_d  = temp_q;
		humid_d = humid_q;
		tfail_d = tfail_q;
		push_valid = 1'b0;
		if (accept) begin
			unique case (pos_eff)
				htfd_pkg::POS_T_LSB: begin
					crc_d  = htfd_pkg::crc8(crc_q, rx.rx_byte);
					temp_d = {temp_q[15:8], rx.rx_byte};
					pos_d  = htfd_pkg::POS_T_CRC;
				end
				htfd_pkg::POS_T_CRC: begin
					tfail_d = (crc_q != rx.rx_byte);
					crc_d   = htfd_pkg::CRC_INIT;
					pos_d   = htfd_pkg::POS_H_MSB;
				end
				htfd_pkg::POS_H_MSB: begin
					crc_d   = htfd_pkg::crc8(htfd_pkg::CRC_INIT, rx.rx_byte);
					humid_d = {rx.rx_byte, 8'h00};
					pos_d   = htfd_pkg::POS_H_LSB;
				end
				htfd_pkg::POS_H_LSB: begin
					crc_d   = htfd_pkg::crc8(crc_q, rx.rx_byte);
					humid_d = {humid_q[15:8], rx.rx_byte};
					pos_d   = htfd_pkg::POS_H_CRC;
				end
				htfd_pkg::POS_H_CRC: begin
					push_valid = 1'b1;
					crc_d      = htfd_pkg::CRC_INIT;
					pos_d      = htfd_pkg::POS_T_MSB;
				end
				default: begin
					// first byte of a frame
					crc_d  = htfd_pkg::crc8(htfd_pkg::CRC_INIT, rx.rx_byte);
					temp_d = {rx.rx_byte, 8'h00};
					pos_d  = htfd_pkg::POS_T_LSB;
				end
			endcase
		end
	end

	always_comb begin
		push_data.temp_raw  = temp_q;
		push_data.humid_raw = humid_q;
		if (tfail_q) begin
			push_data.status = htfd_pkg::ST_TEMP_CRC;
		end else if (crc_q != rx.rx_byte) begin
			push_data.status = htfd_pkg::ST_HUMID_CRC;
		end else begin
			push_data.status = htfd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= htfd_pkg::POS_T_MSB;
			crc_q   <= htfd_pkg::CRC_INIT;
			temp_q  <= '0;
			humid_q <= '0;
			tfail_q <= 1'b0;
		end else begin
			pos_q   <= pos_d;
			crc_q   <= crc_d;
			temp_q  <= temp_d;
			humid_q <= humid_d;
			tfail_q <= tfail_d;
		end
	end

endmodule

>>> rtl/htfd_queue.sv
// Short record queue between front and back end.
// Depends on htfd_pkg.
module htfd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  htfd_pkg::meas_t push_data,
	output logic            push_ready,
	output logic            pop_valid,
	output htfd_pkg::meas_t pop_data,
	input  logic            pop_ready
);

	localparam int PtrW = (htfd_pkg::QUEUE_DEPTH > 1) ? $clog2(htfd_pkg::QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(htfd_pkg::QUEUE_DEPTH + 1);

	htfd_pkg::meas_t     mem_q [htfd_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                do_push, do_pop;

	assign push_ready = (count_q != CntW'(htfd_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(htfd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(htfd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/htfd_back.sv
// Back end: scales the raw words to centi-units (multiply, then divide by
// 65535 via shift-and-correct) and holds the result word. Depends on htfd_pkg.
module htfd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	input  htfd_pkg::meas_t pop_data,
	output logic            pop_ready,
	htfd_result_if.source   res
);

	logic               valid_s1;
	logic [30:0]        tprod_s1;
	logic [29:0]        hprod_s1;
	htfd_pkg::status_t  status_s1;

	logic               out_valid_q;
	logic signed [14:0] temp_q;
	logic [13:0]        humid_q;
	htfd_pkg::status_t  status_q;

	logic               adv_out, load_s1;
	logic [14:0]        tq_hi;
	logic [16:0]        t_rem;
	logic [14:0]        tq;
	logic [13:0]        hq_hi;
	logic [16:0]        h_rem;
	logic [13:0]        hq;
	logic signed [15:0] temp_full;

	assign adv_out   = !out_valid_q || res.ready;
	assign load_s1   = !valid_s1 || adv_out;
	assign pop_ready = load_s1;

	// floor(x / 65535): q = x>>16, remainder (x & 0xFFFF) + q stays below 2*65535
	always_comb begin
		tq_hi = tprod_s1[30:16];
		t_rem = {1'b0, tprod_s1[15:0]} + 17'(tq_hi);
		tq    = tq_hi + 15'(t_rem >= 17'(htfd_pkg::FULL_SCALE));
		hq_hi = hprod_s1[29:16];
		h_rem = {1'b0, hprod_s1[15:0]} + 17'(hq_hi);
		hq    = hq_hi + 14'(h_rem >= 17'(htfd_pkg::FULL_SCALE));
		temp_full = $signed({1'b0, tq}) + 16'(htfd_pkg::TEMP_OFFSET);
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			tprod_s1  <= 31'(pop_data.temp_raw) * 31'(htfd_pkg::TEMP_SCALE);
			hprod_s1  <= 30'(pop_data.humid_raw) * 30'(htfd_pkg::HUMID_SCALE);
			status_s1 <= pop_data.status;
		end
		if (adv_out) begin
			status_q <= status_s1;
			if (status_s1 == htfd_pkg::ST_OK) begin
				temp_q  <= temp_full[14:0];
				humid_q <= hq;
			end else begin
				temp_q  <= '0;
				humid_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= pop_valid;
			end
			if (adv_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	assign res.valid             = out_valid_q;
	assign res.temperature_centi = temp_q;
	assign res.humidity_centi    = humid_q;
	assign res.status            = status_q;

endmodule

>>> rtl/humidity_temp_frame_decoder.sv
// Humidity/temperature sensor frame decoder, top level.
// Depends on htfd_pkg, htfd_if, htfd_front, htfd_queue and htfd_back.
//
// Usage:
//   rx takes one received frame byte per word (rx_byte, frame_start). The
//   frame is temperature MSB, LSB, CRC, humidity MSB, LSB, CRC; frame_start
//   marks a first byte and drops any partial frame. After the sixth byte the
//   next byte starts a new frame on its own.
//   result gives one word per frame: temperature_centi, humidity_centi and
//   status (0 ok, 1 temperature CRC bad, 2 humidity CRC bad; values 0 on error).
//   Throughput: one byte per cycle while rx.ready is high, with the CRC-8
//   step done combinationally. Path: after the sixth byte is accepted the
//   record is written to the queue, goes through the multiply stage, then
//   reaches the divide/output register.
//   Stall: a stalled result holds; the two-entry queue and the pipeline keep
//   taking bytes until the queue is full, then rx.ready drops.
//   Reset: arst_n resets frame position and CRC (to CRC_INIT) and clears all
//   valid flags; the first byte after reset is taken as a frame start.
module humidity_temp_frame_decoder (
	input  logic          clk,
	input  logic          arst_n,
	htfd_byte_if.sink     rx,
	htfd_result_if.source result
);

	logic            push_valid, push_ready;
	htfd_pkg::meas_t push_data;
	logic            pop_valid, pop_ready;
	htfd_pkg::meas_t pop_data;

	htfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	htfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	htfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.res       (result)
	);

endmodule
